// ----- design/hdrscan_pkg.sv -----
// Shared types, constants and the CRC-32 function for the start-header scanner.
package hdrscan_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int WIN_LEN     = 32;
   localparam int SIG_LEN     = 6;
   localparam int CRC_LEN     = 20;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // signature 37 7A BC AF 27 1C, index 0 is the first byte
   localparam logic [SIG_LEN-1:0][7:0] SIG_BYTES = {8'h1C, 8'h27, 8'hAF, 8'hBC, 8'h7A, 8'h37};

   typedef logic [WIN_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } rsp_type;

   typedef struct packed {
      logic                   last;
      logic                   count_ok;
      logic [COUNT_WIDTH-1:0] offset;
      window_type             window;
   } probe_type;

   function automatic logic [31:0] crc_over(input logic [CRC_LEN-1:0][7:0] bytes);
      logic [31:0] c;
      c = CRC_INIT;
      for (int i = 0; i < CRC_LEN; i++) begin
         c = c ^ {24'd0, bytes[i]};
         for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
         end
      end
      return c ^ CRC_XOUT;
   endfunction

endpackage

// ----- design/signature_crc_header_scanner.sv -----
// Top level of the archive start-header scanner.
//
//   channel  direction  handshake        beat
//   req      in         req_push/full    data_byte, last_byte
//   rsp      out        rsp_pop/empty    found, offset
//
// One byte is taken per cycle while req_full is low; a result, when the byte yields one,
// is written to the queue in the cycle after its byte is accepted and can be popped at
// the next edge. The check stage (signature compare and CRC-32 XOR tree over 20 bytes)
// handles one window per cycle. Synchronous reset clears the byte count, first-match flag
// and the queue. req_full rises when the result queue plus the beat in the check stage
// could fill all entries; the queue is four beats deep.
module signature_crc_header_scanner (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  hdrscan_pkg::req_type req_item,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output hdrscan_pkg::rsp_type rsp_item
);

   logic                                accept;
   logic                                probe_valid;
   hdrscan_pkg::probe_type              probe;
   logic                                push;
   hdrscan_pkg::rsp_type                result;
   logic [hdrscan_pkg::FIFO_CW-1:0]     fill;
   logic [hdrscan_pkg::FIFO_CW:0]       pending;

   assign pending  = {1'b0, fill} + {{hdrscan_pkg::FIFO_CW{1'b0}}, probe_valid};
   assign req_full = (pending >= (hdrscan_pkg::FIFO_CW + 1)'(hdrscan_pkg::FIFO_DEPTH));
   assign accept   = req_push && !req_full;

   hdrscan_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .probe_valid (probe_valid),
      .probe       (probe)
   );

   hdrscan_check u_check (
      .clock       (clock),
      .reset       (reset),
      .probe_valid (probe_valid),
      .probe       (probe),
      .push        (push),
      .result      (result)
   );

   hdrscan_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (result),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_item),
      .fill      (fill)
   );

endmodule

// ----- design/hdrscan_front.sv -----
// Front end: takes byte beats, shifts the window, counts bytes and registers a probe.
module hdrscan_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  hdrscan_pkg::req_type   req_item,
   output logic                   probe_valid,
   output hdrscan_pkg::probe_type probe
);

   hdrscan_pkg::window_type             window_ff;
   hdrscan_pkg::window_type             window_in;
   logic [hdrscan_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [hdrscan_pkg::COUNT_WIDTH-1:0] count_in;
   logic [hdrscan_pkg::COUNT_WIDTH-1:0] n_next;
   logic                                was_sat;
   logic                                probe_valid_ff;
   hdrscan_pkg::probe_type              probe_ff;
   hdrscan_pkg::probe_type              probe_in;

   always_comb begin
      window_in = {req_item.data_byte, window_ff[hdrscan_pkg::WIN_LEN-1:1]};
      was_sat   = (count_ff == hdrscan_pkg::COUNT_MAX);
      n_next    = was_sat ? hdrscan_pkg::COUNT_MAX
                          : count_ff + hdrscan_pkg::COUNT_WIDTH'(1);
      count_in  = req_item.last_byte ? '0 : n_next;

      probe_in.last     = req_item.last_byte;
      probe_in.count_ok = (n_next >= hdrscan_pkg::COUNT_WIDTH'(hdrscan_pkg::WIN_LEN));
      probe_in.offset   = was_sat ? hdrscan_pkg::COUNT_MAX
                                  : n_next - hdrscan_pkg::COUNT_WIDTH'(hdrscan_pkg::WIN_LEN);
      probe_in.window   = window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         probe_valid_ff <= 1'b0;
      end else begin
         probe_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
         probe_ff  <= probe_in;
      end
   end

   assign probe_valid = probe_valid_ff;
   assign probe       = probe_ff;

endmodule

// ----- design/hdrscan_check.sv -----
// Back end: signature and CRC check on each probe, first-match tracking, result push.
module hdrscan_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   probe_valid,
   input  hdrscan_pkg::probe_type probe,
   output logic                   push,
   output hdrscan_pkg::rsp_type   result
);

   logic        match_done_ff;
   logic        match_done_in;
   logic        sig_ok;
   logic [31:0] stored_crc;
   logic [31:0] calc_crc;
   logic        hit;

   always_comb begin
      sig_ok     = (probe.window[hdrscan_pkg::SIG_LEN-1:0] == hdrscan_pkg::SIG_BYTES);
      stored_crc = {probe.window[11], probe.window[10], probe.window[9], probe.window[8]};
      calc_crc   = hdrscan_pkg::crc_over(probe.window[hdrscan_pkg::WIN_LEN-1:12]);
      hit        = probe_valid && !match_done_ff && probe.count_ok && sig_ok
                   && (calc_crc == stored_crc);
      push       = hit || (probe_valid && probe.last && !match_done_ff);

      result.found  = hit;
      result.offset = hit ? 32'(probe.offset) : 32'd0;

      match_done_in = match_done_ff;
      if (probe_valid) begin
         match_done_in = probe.last ? 1'b0 : (match_done_ff | hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_done_ff <= 1'b0;
      end else begin
         match_done_ff <= match_done_in;
      end
   end

endmodule

// ----- design/hdrscan_fifo.sv -----
// Result queue between the check stage and the response port.
module hdrscan_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  hdrscan_pkg::rsp_type              push_item,
   input  logic                              pop,
   output logic                              empty,
   output hdrscan_pkg::rsp_type              head,
   output logic [hdrscan_pkg::FIFO_CW-1:0]   fill
);

   hdrscan_pkg::rsp_type                mem_ff [hdrscan_pkg::FIFO_DEPTH];
   logic [hdrscan_pkg::FIFO_AW-1:0]     wr_ptr_ff;
   logic [hdrscan_pkg::FIFO_AW-1:0]     rd_ptr_ff;
   logic [hdrscan_pkg::FIFO_CW-1:0]     count_ff;
   logic [hdrscan_pkg::FIFO_CW-1:0]     count_in;
   logic                                do_pop;

   always_comb begin
      do_pop   = pop && (count_ff != '0);
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + hdrscan_pkg::FIFO_CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - hdrscan_pkg::FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + hdrscan_pkg::FIFO_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + hdrscan_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];
   assign fill  = count_ff;

endmodule
